// ===== hw/rtl/tcd_pkg.sv =====
// Shared types and constants for the triple coincidence detector.
package tcd_pkg;

  localparam int unsigned TimeBits  = 48;
  localparam int unsigned CountBits = 32;
  localparam int unsigned DiffBits  = 20;
  localparam int unsigned CodeBits  = 8;
  localparam int unsigned WinBits   = 20;
  localparam int unsigned NumDet    = 3;

  localparam int unsigned InDataBits  = 56;
  localparam int unsigned OutDataBits = 176;
  localparam int unsigned CfgAddrBits = 2;
  localparam int unsigned CfgDataBits = WinBits;

  typedef enum logic [CfgAddrBits-1:0] {
    REG_WINDOW_TICKS = 2'd0,
    REG_CODE_FIRST   = 2'd1,
    REG_CODE_SECOND  = 2'd2,
    REG_CODE_THIRD   = 2'd3
  } tcd_reg_t;

  typedef enum logic [1:0] {
    DET_FIRST  = 2'd0,
    DET_SECOND = 2'd1,
    DET_THIRD  = 2'd2
  } tcd_det_t;

  localparam logic [WinBits-1:0]  WindowTicksRst = 20'd480;
  localparam logic [CodeBits-1:0] CodeFirstRst   = 8'd2;
  localparam logic [CodeBits-1:0] CodeSecondRst  = 8'd8;
  localparam logic [CodeBits-1:0] CodeThirdRst   = 8'd64;

  typedef struct packed {
    logic [WinBits-1:0]  window_ticks;
    logic [CodeBits-1:0] code_first;
    logic [CodeBits-1:0] code_second;
    logic [CodeBits-1:0] code_third;
  } tcd_cfg_t;

  // Field order follows the output tdata packing, first field in the top bits.
  typedef struct packed {
    logic [TimeBits-1:0]  shower_interval;
    logic                 interval_valid;
    logic [DiffBits-1:0]  diff_first_third;
    logic [DiffBits-1:0]  diff_second_third;
    logic [DiffBits-1:0]  diff_first_second;
    logic [CountBits-1:0] true_count;
    logic [CountBits-1:0] candidate_count;
    logic                 true_triple;
    logic                 candidate_triple;
    logic                 hit_accepted;
  } tcd_result_t;

endpackage

// ===== hw/rtl/tcd_core.sv =====
// Window state, triple classification and counters for one hit per cycle while step is high.
module tcd_core
  import tcd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  tcd_cfg_t            cfg,
  input  logic [CodeBits-1:0] channel_code,
  input  logic [TimeBits-1:0] hit_time,
  output tcd_result_t         result
);

  logic [1:0]           win_det_r    [NumDet];
  logic [TimeBits-1:0]  win_time_r   [NumDet];
  logic [1:0]           win_fill_r;
  logic [CountBits-1:0] cand_cnt_r;
  logic [CountBits-1:0] true_cnt_r;
  logic [TimeBits-1:0]  last_start_r;
  logic                 have_last_r;

  logic [1:0]           win_det_nxt  [NumDet];
  logic [TimeBits-1:0]  win_time_nxt [NumDet];
  logic [1:0]           win_fill_nxt;
  logic [CountBits-1:0] cand_cnt_nxt;
  logic [CountBits-1:0] true_cnt_nxt;
  logic [TimeBits-1:0]  last_start_nxt;
  logic                 have_last_nxt;

  logic                 acc;
  tcd_det_t             det;
  logic                 cand;
  logic                 tru;
  logic [TimeBits-1:0]  span;
  logic [1:0]           pos [NumDet];
  logic [TimeBits-1:0]  t_of_det [NumDet];
  logic [TimeBits-1:0]  d01, d12, d02;

  always_comb begin
    acc = 1'b1;
    det = DET_FIRST;
    priority if (channel_code == cfg.code_first) begin
      det = DET_FIRST;
    end else if (channel_code == cfg.code_second) begin
      det = DET_SECOND;
    end else if (channel_code == cfg.code_third) begin
      det = DET_THIRD;
    end else begin
      acc = 1'b0;
    end
  end

  always_comb begin
    win_det_nxt[0]  = win_det_r[1];
    win_det_nxt[1]  = win_det_r[2];
    win_det_nxt[2]  = det;
    win_time_nxt[0] = win_time_r[1];
    win_time_nxt[1] = win_time_r[2];
    win_time_nxt[2] = hit_time;
    win_fill_nxt    = (win_fill_r == 2'd3) ? 2'd3 : win_fill_r + 2'd1;
  end

  assign span = win_time_nxt[2] - win_time_nxt[0];
  assign cand = acc && (win_fill_nxt == 2'd3) &&
                (win_det_nxt[0] != win_det_nxt[1]) &&
                (win_det_nxt[1] != win_det_nxt[2]) &&
                (win_det_nxt[0] != win_det_nxt[2]);
  assign tru  = cand && (span < {{(TimeBits-WinBits){1'b0}}, cfg.window_ticks});

  // Slot of each detector; only meaningful when the three slots are distinct.
  always_comb begin
    for (int d = 0; d < NumDet; d++) begin
      pos[d] = 2'd0;
      for (int s = 0; s < NumDet; s++) begin
        if (win_det_nxt[s] == 2'(d)) begin
          pos[d] = 2'(s);
        end
      end
      t_of_det[d] = win_time_nxt[pos[d]];
    end
  end

  assign d01 = (pos[0] < pos[1]) ? t_of_det[1] - t_of_det[0] : t_of_det[0] - t_of_det[1];
  assign d12 = (pos[1] < pos[2]) ? t_of_det[2] - t_of_det[1] : t_of_det[1] - t_of_det[2];
  assign d02 = (pos[0] < pos[2]) ? t_of_det[2] - t_of_det[0] : t_of_det[0] - t_of_det[2];

  always_comb begin
    cand_cnt_nxt   = cand_cnt_r;
    true_cnt_nxt   = true_cnt_r;
    last_start_nxt = last_start_r;
    have_last_nxt  = have_last_r;
    if (cand && (cand_cnt_r != {CountBits{1'b1}})) begin
      cand_cnt_nxt = cand_cnt_r + 1'b1;
    end
    if (tru) begin
      if (true_cnt_r != {CountBits{1'b1}}) begin
        true_cnt_nxt = true_cnt_r + 1'b1;
      end
      last_start_nxt = win_time_nxt[0];
      have_last_nxt  = 1'b1;
    end
  end

  always_comb begin
    result                   = '0;
    result.hit_accepted      = acc;
    result.candidate_triple  = cand;
    result.true_triple       = tru;
    result.candidate_count   = cand_cnt_nxt;
    result.true_count        = true_cnt_nxt;
    if (tru) begin
      result.diff_first_second = d01[DiffBits-1:0];
      result.diff_second_third = d12[DiffBits-1:0];
      result.diff_first_third  = d02[DiffBits-1:0];
      if (have_last_r) begin
        result.interval_valid  = 1'b1;
        result.shower_interval = win_time_nxt[0] - last_start_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NumDet; s++) begin
        win_det_r[s]  <= '0;
        win_time_r[s] <= '0;
      end
      win_fill_r   <= '0;
      cand_cnt_r   <= '0;
      true_cnt_r   <= '0;
      last_start_r <= '0;
      have_last_r  <= 1'b0;
    end else if (step && acc) begin
      for (int s = 0; s < NumDet; s++) begin
        win_det_r[s]  <= win_det_nxt[s];
        win_time_r[s] <= win_time_nxt[s];
      end
      win_fill_r   <= win_fill_nxt;
      cand_cnt_r   <= cand_cnt_nxt;
      true_cnt_r   <= true_cnt_nxt;
      last_start_r <= last_start_nxt;
      have_last_r  <= have_last_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    win_fill_r != 2'd0 |=> win_fill_r != 2'd0)
    else $error("window fill dropped back to empty");

  a_true_le_cand: assert property (@(posedge clk) disable iff (!rst_n)
    true_cnt_r <= cand_cnt_r)
    else $error("true count exceeds candidate count");

  a_last_needs_true: assert property (@(posedge clk) disable iff (!rst_n)
    have_last_r |-> true_cnt_r != '0)
    else $error("previous triple recorded without a true count");

  a_true_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    step && tru |=> win_fill_r == 2'd3)
    else $error("true triple from a window that is not full");
`endif

endmodule

// ===== hw/rtl/triple_coincidence_detector.sv =====
// Top level of the triple coincidence detector: registers, input and output stages.
//
// Channel   Dir  Signals                              Payload
// in_       in   in_tvalid/in_tready/in_tdata         one detector hit
// out_      out  out_tvalid/out_tready/out_tdata      one result per hit
// cfg_      in   cfg_we/cfg_addr/cfg_wdata            register writes
//
// One hit enters per cycle unless the output stalls; each hit passes the input register,
// the core and the result register before its result appears.
// A stalled output holds the result register; the input register still takes a hit
// while the result register is full, then the input side stalls.
// Reset clears the window, counters and valid flags and loads the config reset values.
module triple_coincidence_detector
  import tcd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [InDataBits-1:0]  in_tdata,   // channel_code, hit_time
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // hit_accepted, candidate_triple, true_triple, candidate_count, true_count,
  // diff_first_second, diff_second_third, diff_first_third, interval_valid,
  // shower_interval
  output logic [OutDataBits-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CfgAddrBits-1:0] cfg_addr,
  input  logic [CfgDataBits-1:0] cfg_wdata
);

  tcd_cfg_t            cfg_r;
  logic                in_vld_r;
  logic [CodeBits-1:0] code_r;
  logic [TimeBits-1:0] time_r;
  logic                out_vld_r;
  tcd_result_t         out_data_r;
  tcd_result_t         result;
  logic                advance;
  logic                step;

  assign advance   = !out_vld_r || out_tready;
  assign step      = in_vld_r && advance;
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_ticks <= WindowTicksRst;
      cfg_r.code_first   <= CodeFirstRst;
      cfg_r.code_second  <= CodeSecondRst;
      cfg_r.code_third   <= CodeThirdRst;
    end else if (cfg_we) begin
      unique case (tcd_reg_t'(cfg_addr))
        REG_WINDOW_TICKS: cfg_r.window_ticks <= cfg_wdata;
        REG_CODE_FIRST:   cfg_r.code_first   <= cfg_wdata[CodeBits-1:0];
        REG_CODE_SECOND:  cfg_r.code_second  <= cfg_wdata[CodeBits-1:0];
        REG_CODE_THIRD:   cfg_r.code_third   <= cfg_wdata[CodeBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      code_r <= in_tdata[CodeBits-1:0];
      time_r <= in_tdata[CodeBits +: TimeBits];
    end
  end

  tcd_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .cfg          (cfg_r),
    .channel_code (code_r),
    .hit_time     (time_r),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_true_is_cand: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_data_r.true_triple |-> out_data_r.candidate_triple)
    else $error("true triple without candidate triple");

  a_cand_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_data_r.candidate_triple |-> out_data_r.hit_accepted)
    else $error("candidate triple from a rejected hit");

  a_interval_is_true: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_data_r.interval_valid |-> out_data_r.true_triple)
    else $error("interval reported without a true triple");
`endif

endmodule

// ===== tb/triple_coincidence_detector_test.sv =====
// Self-checking testbench for the triple coincidence detector with a scoreboard class.
module triple_coincidence_detector_test;
  import tcd_pkg::*;

  class coincidence_scoreboard;
    tcd_cfg_t             cfg;
    tcd_det_t             slot_det[3];
    logic [TimeBits-1:0]  slot_time[3];
    int unsigned          fill;
    logic [CountBits-1:0] candidate_total;
    logic [CountBits-1:0] true_total;
    logic [TimeBits-1:0]  last_true_start;
    bit                   have_last_true;
    tcd_result_t          awaited[$];
    int unsigned          errors;

    function new();
      cfg.window_ticks = WindowTicksRst;
      cfg.code_first   = CodeFirstRst;
      cfg.code_second  = CodeSecondRst;
      cfg.code_third   = CodeThirdRst;
      for (int i = 0; i < 3; i++) begin
        slot_det[i]  = DET_FIRST;
        slot_time[i] = '0;
      end
      fill            = 0;
      candidate_total = '0;
      true_total      = '0;
      last_true_start = '0;
      have_last_true  = 1'b0;
      errors          = 0;
    endfunction

    function void set_reg(tcd_reg_t idx, logic [CfgDataBits-1:0] val);
      case (idx)
        REG_WINDOW_TICKS: cfg.window_ticks = val;
        REG_CODE_FIRST:   cfg.code_first   = val[CodeBits-1:0];
        REG_CODE_SECOND:  cfg.code_second  = val[CodeBits-1:0];
        REG_CODE_THIRD:   cfg.code_third   = val[CodeBits-1:0];
        default: ;
      endcase
    endfunction

    function logic [DiffBits-1:0] pair_gap(tcd_det_t a, tcd_det_t b);
      int unsigned         pa;
      int unsigned         pb;
      int unsigned         tmp;
      logic [TimeBits-1:0] d;
      pa = 0;
      pb = 0;
      for (int i = 0; i < 3; i++) begin
        if (slot_det[i] == a) pa = i;
        if (slot_det[i] == b) pb = i;
      end
      if (pa > pb) begin
        tmp = pa;
        pa  = pb;
        pb  = tmp;
      end
      d = slot_time[pb] - slot_time[pa];
      return d[DiffBits-1:0];
    endfunction

    function void note_hit(logic [CodeBits-1:0] code, logic [TimeBits-1:0] t);
      tcd_result_t         r;
      tcd_det_t            det;
      logic [TimeBits-1:0] span;
      r = '0;
      det = DET_FIRST;
      r.hit_accepted = 1'b1;
      if (code == cfg.code_first) det = DET_FIRST;
      else if (code == cfg.code_second) det = DET_SECOND;
      else if (code == cfg.code_third) det = DET_THIRD;
      else r.hit_accepted = 1'b0;
      if (r.hit_accepted) begin
        slot_det[0]  = slot_det[1];
        slot_det[1]  = slot_det[2];
        slot_det[2]  = det;
        slot_time[0] = slot_time[1];
        slot_time[1] = slot_time[2];
        slot_time[2] = t;
        if (fill < 3) fill++;
        span = slot_time[2] - slot_time[0];
        if (fill == 3 && slot_det[0] != slot_det[1] && slot_det[1] != slot_det[2] &&
            slot_det[0] != slot_det[2]) begin
          r.candidate_triple = 1'b1;
          if (candidate_total != '1) candidate_total++;
          if (span < TimeBits'(cfg.window_ticks)) begin
            r.true_triple = 1'b1;
            if (true_total != '1) true_total++;
            r.diff_first_second = pair_gap(DET_FIRST, DET_SECOND);
            r.diff_second_third = pair_gap(DET_SECOND, DET_THIRD);
            r.diff_first_third  = pair_gap(DET_FIRST, DET_THIRD);
            if (have_last_true) begin
              r.interval_valid  = 1'b1;
              r.shower_interval = slot_time[0] - last_true_start;
            end
            last_true_start = slot_time[0];
            have_last_true  = 1'b1;
          end
        end
      end
      r.candidate_count = candidate_total;
      r.true_count      = true_total;
      awaited = {awaited, r};
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      errors++;
    endtask

    task compare_field(string what, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_mismatch(what, got, want);
    endtask

    task check_result(tcd_result_t got);
      tcd_result_t want;
      if (awaited.size() == 0) begin
        report_mismatch("unexpected result", got.candidate_count, 0);
      end else begin
        want = awaited.pop_front();
        compare_field("hit_accepted", got.hit_accepted, want.hit_accepted);
        compare_field("candidate_triple", got.candidate_triple, want.candidate_triple);
        compare_field("true_triple", got.true_triple, want.true_triple);
        compare_field("candidate_count", got.candidate_count, want.candidate_count);
        compare_field("true_count", got.true_count, want.true_count);
        compare_field("diff_first_second", got.diff_first_second, want.diff_first_second);
        compare_field("diff_second_third", got.diff_second_third, want.diff_second_third);
        compare_field("diff_first_third", got.diff_first_third, want.diff_first_third);
        compare_field("interval_valid", got.interval_valid, want.interval_valid);
        compare_field("shower_interval", got.shower_interval, want.shower_interval);
      end
    endtask
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [InDataBits-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OutDataBits-1:0] out_tdata;
  logic                   cfg_we     = 1'b0;
  logic [CfgAddrBits-1:0] cfg_addr   = REG_WINDOW_TICKS;
  logic [CfgDataBits-1:0] cfg_wdata  = '0;

  coincidence_scoreboard sb;
  logic [TimeBits-1:0]   hit_clock;
  int unsigned           burst_left = 0;
  int unsigned           ready_tick = 0;

  localparam logic [TimeBits-1:0] TimeMax = '1;

  logic [CodeBits-1:0] directed_code[20] = '{
    8'd0, 8'd255, 8'd2, 8'd8, 8'd64, 8'd2, 8'd2, 8'd8, 8'd64, 8'd2,
    8'd8, 8'd64, 8'd2, 8'd1, 8'd8, 8'd64, 8'd2, 8'd8, 8'd64, 8'd2
  };
  logic [TimeBits-1:0] directed_time[20] = '{
    48'd0, 48'd5, 48'd10, 48'd20, 48'd30, 48'd100, 48'd110, 48'd200, 48'd689, 48'd690,
    48'd1000, 48'd1169, 48'd1480, 48'd1480, 48'd1480, 48'd100, TimeMax, TimeMax, TimeMax,
    48'd5
  };

  triple_coincidence_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(tcd_result_t'(out_tdata));
    ready_tick++;
    case (ready_tick[9:8])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 3) != 0);
      2'd2: out_tready <= (ready_tick[1:0] == 2'd0);
      default: out_tready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  task automatic send_hit(logic [CodeBits-1:0] code, logic [TimeBits-1:0] t);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {t, code};
    do @(posedge clk); while (!in_tready);
    sb.note_hit(code, t);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(tcd_reg_t idx, logic [CfgDataBits-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(logic [WinBits-1:0] win, logic [CodeBits-1:0] c_first,
                           logic [CodeBits-1:0] c_second, logic [CodeBits-1:0] c_third);
    put_reg(REG_WINDOW_TICKS, win);
    put_reg(REG_CODE_FIRST, CfgDataBits'(c_first));
    put_reg(REG_CODE_SECOND, CfgDataBits'(c_second));
    put_reg(REG_CODE_THIRD, CfgDataBits'(c_third));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [TimeBits-1:0] next_hit_time();
    case ($urandom_range(0, 19))
      0: hit_clock -= TimeBits'($urandom_range(1, 1000));
      1: hit_clock += TimeBits'($urandom);
      default: hit_clock += TimeBits'($urandom_range(0, sb.cfg.window_ticks / 3 + 1));
    endcase
    return hit_clock;
  endfunction

  task automatic random_hits(int unsigned count);
    int unsigned         sent;
    int unsigned         d0;
    int unsigned         d1;
    logic [CodeBits-1:0] codes[3];
    sent = 0;
    codes[0] = sb.cfg.code_first;
    codes[1] = sb.cfg.code_second;
    codes[2] = sb.cfg.code_third;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 6) begin
        d0 = $urandom_range(0, 2);
        d1 = (d0 + $urandom_range(1, 2)) % 3;
        send_hit(codes[d0], next_hit_time());
        send_hit(codes[d1], next_hit_time());
        send_hit(codes[3 - d0 - d1], next_hit_time());
        sent += 3;
      end else begin
        if ($urandom_range(0, 2) == 0) send_hit(codes[$urandom_range(0, 2)], next_hit_time());
        else send_hit(CodeBits'($urandom), next_hit_time());
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 20; i++) send_hit(directed_code[i], directed_time[i]);
    hit_clock = {16'($urandom), $urandom};
    random_hits(100);
    drain();

    configure('1, 8'h00, 8'hFF, 8'h5A);
    hit_clock = {16'($urandom), $urandom};
    random_hits(100);
    drain();

    configure('0, 8'd1, 8'd2, 8'd3);
    random_hits(100);
    drain();

    configure(20'd1, 8'hA5, 8'hA5, 8'h0F);
    random_hits(100);
    drain();

    configure(WinBits'($urandom_range(1, 5000)), CodeBits'($urandom), CodeBits'($urandom),
              CodeBits'($urandom));
    hit_clock = {16'($urandom), $urandom};
    random_hits(100);
    drain();

    configure(20'd100, 8'd7, 8'd7, 8'd7);
    random_hits(100);
    drain();

    configure(20'd4000, 8'h80, 8'h40, 8'h01);
    hit_clock = TimeMax - 48'd30000;
    random_hits(100);
    drain();

    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== triple_coincidence_detector.f =====
hw/rtl/tcd_pkg.sv
hw/rtl/tcd_core.sv
hw/rtl/triple_coincidence_detector.sv
tb/triple_coincidence_detector_test.sv
